// File: sv/lba_to_disk_geometry_search_top_defines.svh
// ----------------------------------------------------------------------------
// LBA to disk geometry search - assertion macros
// Shared property wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef LBA_TO_DISK_GEOMETRY_SEARCH_TOP_DEFINES_SVH
`define LBA_TO_DISK_GEOMETRY_SEARCH_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define LDGS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define LDGS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ldgs_pkg.sv
// ----------------------------------------------------------------------------
// ldgs_pkg
// Types and constants shared by the geometry search modules.
// ----------------------------------------------------------------------------
package ldgs_pkg;

    localparam logic [1:0] OP_STD   = 2'd0;
    localparam logic [1:0] OP_LARGE = 2'd1;
    localparam logic [1:0] OP_IDE   = 2'd2;

    localparam logic [7:0]  SECT_STD = 8'd63;
    localparam logic [7:0]  SECT_IDE = 8'd255;
    localparam logic [15:0] CMAX_STD = 16'd1023;
    localparam logic [15:0] CMAX_IDE = 16'd65534;

    localparam int LBA_W  = 32;
    localparam int Q_W    = 27;            // lba / 63 < 2**27
    localparam int PROD_W = 24;            // 255 * 65534 < 2**24

    // job word passed from front to back
    typedef struct packed {
        logic [LBA_W-1:0] lba;
        logic             large_mode;
        logic             ide;
    } t_job;

endpackage

// File: sv/ldgs_front.sv
// ----------------------------------------------------------------------------
// ldgs_front
// Input stage: takes a word, decodes the mode, holds it until queued.
// ----------------------------------------------------------------------------
module ldgs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [31:0]       i_lba,
    input  logic [1:0]        i_opcode,
    output logic              o_valid,
    input  logic              i_ready,
    output ldgs_pkg::t_job    o_job
);
    import ldgs_pkg::*;

    logic r_valid;
    logic n_valid;
    t_job r_job;
    t_job n_job;
    logic accept;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_job     = r_job;
        n_job.lba = i_lba;
        // unused code 3 runs as standard
        case (i_opcode)
            OP_LARGE: begin
                n_job.large_mode = 1'b1;
                n_job.ide        = 1'b0;
            end
            OP_IDE: begin
                n_job.large_mode = 1'b0;
                n_job.ide        = 1'b1;
            end
            default: begin
                n_job.large_mode = 1'b0;
                n_job.ide        = 1'b0;
            end
        endcase
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_job <= n_job;
        end
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;

endmodule

// File: sv/ldgs_queue.sv
// ----------------------------------------------------------------------------
// ldgs_queue
// Small FIFO of decoded jobs between front and back.
// ----------------------------------------------------------------------------
module ldgs_queue #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ldgs_pkg::t_job    i_job,
    output logic              o_valid,
    input  logic              i_ready,
    output ldgs_pkg::t_job    o_job
);
    import ldgs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_job          r_slot [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;
    logic [CW-1:0] n_cnt;
    logic          push;
    logic          pop;

    assign o_ready = (r_cnt != FULL);
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_slot[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + 1'b1;
        end
        case ({push, pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (push) begin
            r_slot[r_wr] <= i_job;
        end
    end

endmodule

// File: sv/ldgs_back.sv
// ----------------------------------------------------------------------------
// ldgs_back
// Search engine: for h = 1..255, c = min(lba/(S*h), cmax) by a restoring
// divider; keep the best h*c (ties to later h). Divisor S*h steps by S.
// ----------------------------------------------------------------------------
module ldgs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ldgs_pkg::t_job    i_job,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [15:0]       o_cylinders,
    output logic [7:0]        o_heads,
    output logic [7:0]        o_sectors
);
    import ldgs_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HDIV  = 3'd1;
    localparam logic [2:0] S_CLAMP = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // top lba bits stay below any divisor (S*h >= 63), so they preload the remainder
    localparam int         HI_W    = LBA_W - Q_W;
    localparam logic [5:0] STEPS_H = 6'(Q_W);

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic              r_large;
    logic              r_ide;
    logic [LBA_W-1:0]  r_lba;
    // divider
    logic [LBA_W-1:0]  r_dvd;
    logic [15:0]       r_dvs;
    logic [15:0]       r_rem;
    logic [Q_W-1:0]    r_quo;
    logic [5:0]        r_cnt;
    logic [16:0]       rem_sh;
    logic              ge;
    logic [7:0]        sect;
    // search
    logic [7:0]        r_h;
    logic [15:0]       r_c;
    logic [PROD_W-1:0] r_p;
    logic [15:0]       r_best_c;
    logic [7:0]        r_best_h;
    logic [PROD_W-1:0] r_best_p;
    logic [15:0]       cmax;
    // output register
    logic              r_out_valid;
    logic [15:0]       r_out_cyl;
    logic [7:0]        r_out_head;
    logic [7:0]        r_out_sect;
    logic              out_load;

    assign rem_sh   = {r_rem, r_dvd[LBA_W-1]};
    assign ge       = (rem_sh >= {1'b0, r_dvs});
    assign sect     = r_ide ? SECT_IDE : SECT_STD;
    assign cmax     = r_ide ? CMAX_IDE : CMAX_STD;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_ready);
    assign o_ready  = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid) n_state = S_HDIV;
            S_HDIV:  if (r_cnt == 6'd1) n_state = S_CLAMP;
            S_CLAMP: n_state = S_MUL;
            S_MUL:   n_state = S_CMP;
            S_CMP:   n_state = (r_h == 8'd255) ? S_DONE : S_HDIV;
            S_DONE:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_large  <= i_job.large_mode;
                    r_ide    <= i_job.ide;
                    r_lba    <= i_job.lba;
                    r_dvd    <= {i_job.lba[Q_W-1:0], {HI_W{1'b0}}};
                    r_rem    <= {{(16-HI_W){1'b0}}, i_job.lba[LBA_W-1:Q_W]};
                    r_dvs    <= {8'd0, (i_job.ide ? SECT_IDE : SECT_STD)};
                    r_quo    <= '0;
                    r_cnt    <= STEPS_H;
                    r_h      <= 8'd1;
                    r_best_p <= '0;
                    r_best_h <= '0;
                    r_best_c <= '0;
                end
            end
            S_HDIV: begin
                r_rem <= ge ? 16'(rem_sh - {1'b0, r_dvs}) : rem_sh[15:0];
                r_dvd <= {r_dvd[LBA_W-2:0], 1'b0};
                r_quo <= {r_quo[Q_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
            end
            S_CLAMP: begin
                r_c <= (r_quo > {{(Q_W-16){1'b0}}, cmax}) ? cmax : r_quo[15:0];
            end
            S_MUL: begin
                r_p <= {{(PROD_W-8){1'b0}}, r_h} * {{(PROD_W-16){1'b0}}, r_c};
            end
            S_CMP: begin
                if (r_p >= r_best_p) begin
                    r_best_p <= r_p;
                    r_best_h <= r_h;
                    r_best_c <= r_c;
                end
                r_h   <= r_h + 1'b1;
                r_dvs <= r_dvs + {8'd0, sect};
                r_dvd <= {r_lba[Q_W-1:0], {HI_W{1'b0}}};
                r_rem <= {{(16-HI_W){1'b0}}, r_lba[LBA_W-1:Q_W]};
                r_quo <= '0;
                r_cnt <= STEPS_H;
            end
            S_DONE: begin
                if (out_load) begin
                    r_out_cyl  <= r_large ? {1'b0, r_best_c[15:1]} : r_best_c;
                    r_out_head <= r_large ? {r_best_h[6:0], 1'b0} : r_best_h;
                    r_out_sect <= sect;
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    assign o_valid     = r_out_valid;
    assign o_cylinders = r_out_cyl;
    assign o_heads     = r_out_head;
    assign o_sectors   = r_out_sect;

endmodule

// File: sv/lba_to_disk_geometry_search_top.sv
// ----------------------------------------------------------------------------
// lba_to_disk_geometry_search_top
// Translates a disk size in sectors to a cylinder/head/sector geometry.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                     | tuser
//  s_axis  | in  | [31:0] lba                             | [1:0] opcode
//  m_axis  | out | [15:0] cyl, [23:16] heads, [31:24] sect | -
//
//  Flow: a word passes through the front register and the queue; then, per
//  head count, the engine runs 27 divide steps for lba/(S*h) plus clamp,
//  multiply and compare, and at last loads the result into the output register.
//  The engine takes no new word until its last result is loaded out.
//  Reset: i_rst_n synchronous, active low; clears input stage, queue and engine control.
//  Stalls: the input stage and the job queue keep taking words while the
//  engine works, until both are full; a finished result sits in the output register until taken.
// ----------------------------------------------------------------------------
module lba_to_disk_geometry_search_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] lba
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [15:0] cylinders, [23:16] heads, [31:24] sectors
);
    import ldgs_pkg::*;

    // front -> queue
    logic fq_valid;
    logic fq_ready;
    t_job fq_job;
    // queue -> back
    logic qb_valid;
    logic qb_ready;
    t_job qb_job;

    ldgs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_lba    (s_axis_tdata),
        .i_opcode (s_axis_tuser),
        .o_valid  (fq_valid),
        .i_ready  (fq_ready),
        .o_job    (fq_job)
    );

    ldgs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_job   (fq_job),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_job   (qb_job)
    );

    // engine result fields land directly in the output word
    ldgs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (qb_valid),
        .o_ready     (qb_ready),
        .i_job       (qb_job),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_cylinders (m_axis_tdata[15:0]),
        .o_heads     (m_axis_tdata[23:16]),
        .o_sectors   (m_axis_tdata[31:24])
    );

endmodule

// File: sv/ldgs_checker.sv
// ----------------------------------------------------------------------------
// ldgs_checker
// Port-level checks for the geometry search, bound to the top level.
// ----------------------------------------------------------------------------
`include "lba_to_disk_geometry_search_top_defines.svh"

module ldgs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] i_m_tdata
);

    // held result stays put
    `LDGS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata), "result changed while stalled")

    // sectors per track is one of the two track sizes
    `LDGS_ASSERT_NOW(a_sect_legal, i_clk, i_rst_n, i_m_tvalid, (i_m_tdata[31:24] == 8'd63) || (i_m_tdata[31:24] == 8'd255), "bad sectors per track")

    // 63-sector modes keep the cylinder count within 10 bits
    `LDGS_ASSERT_NOW(a_cyl_range, i_clk, i_rst_n, i_m_tvalid && (i_m_tdata[31:24] == 8'd63), i_m_tdata[15:0] <= 16'd1023, "cylinders above limit")

endmodule

bind lba_to_disk_geometry_search_top ldgs_checker u_ldgs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);
